>>> sv/bdq_pkg.sv
// Shared constants, codes and types for the bounded deque with erase.
package bdq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_ERASE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

>>> sv/bdq_ctrl.sv
// Controller state machine that sequences accept, execute and response.
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bdq_pkg::cmd_type cmd
);

   bdq_pkg::state_type state_ff;
   bdq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bdq_pkg::S_EXEC;
            end
         end
         bdq_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = bdq_pkg::S_RESP;
         end
         bdq_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bdq_pkg::S_IDLE;
         end
      endcase
   end

   a_no_accept_while_responding: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("request beat accepted while a response is pending");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec)
      else $error("accepted beat not executed in the next cycle");

   a_exec_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("execution not followed by a response beat");

endmodule

>>> sv/bdq_datapath.sv
// Datapath: cell chain with per-cell compare and shift, count and result registers.
module bdq_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bdq_pkg::cmd_type                      cmd,
   input  logic [bdq_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [bdq_pkg::WORD_W-1:0]     req_value,
   output logic signed [bdq_pkg::WORD_W-1:0]     rsp_removed_value,
   output logic [bdq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]           rsp_count
);

   localparam int CAP   = bdq_pkg::CAPACITY;
   localparam int CNT_W = bdq_pkg::CNT_W;

   bdq_pkg::kind_type                  kind_ff;
   logic [bdq_pkg::WORD_W-1:0]         value_ff;
   logic [bdq_pkg::WORD_W-1:0]         cells_ff [CAP];
   logic [bdq_pkg::WORD_W-1:0]         cells_in [CAP];
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic [bdq_pkg::WORD_W-1:0]         removed_ff;
   logic [bdq_pkg::WORD_W-1:0]         removed_in;
   bdq_pkg::status_type                status_ff;
   bdq_pkg::status_type                status_in;

   logic           full;
   logic           empty;
   logic           found;
   logic [CAP-1:0] live;
   logic [CAP-1:0] hit;
   logic [CAP-1:0] erase_mask;

   assign full  = (count_ff == CNT_W'(CAP));
   assign empty = (count_ff == '0);
   assign found = |hit;

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         live[i] = (CNT_W'(i) < count_ff);
         hit[i]  = live[i] && (cells_ff[i] == value_ff);
      end
      for (int i = 0; i < CAP; i++) begin
         erase_mask[i] = 1'b0;
         for (int j = 0; j <= i; j++) begin
            erase_mask[i] = erase_mask[i] | hit[j];
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      removed_in = '0;
      status_in  = bdq_pkg::ST_OK;
      for (int i = 0; i < CAP; i++) begin
         cells_in[i] = cells_ff[i];
      end
      case (kind_ff)
         bdq_pkg::KIND_APPEND: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < CAP; i++) begin
                  if (CNT_W'(i) == count_ff) begin
                     cells_in[i] = value_ff;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         bdq_pkg::KIND_INSERT: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               cells_in[0] = value_ff;
               for (int i = 1; i < CAP; i++) begin
                  cells_in[i] = cells_ff[i-1];
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         bdq_pkg::KIND_REMOVE: begin
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               removed_in = cells_ff[0];
               for (int i = 0; i < CAP - 1; i++) begin
                  cells_in[i] = cells_ff[i+1];
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         bdq_pkg::KIND_ERASE: begin
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else if (!found) begin
               status_in = bdq_pkg::ST_NOT_FOUND;
            end else begin
               for (int i = 0; i < CAP - 1; i++) begin
                  if (erase_mask[i]) begin
                     cells_in[i] = cells_ff[i+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = bdq_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= bdq_pkg::kind_type'(req_kind);
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
         for (int i = 0; i < CAP; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_count         = bdq_pkg::COUNT_W'(count_ff);

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP))
      else $error("element count above capacity");

   a_remove_decrements: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == bdq_pkg::KIND_REMOVE && !empty)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not decrement the count");

   a_full_insert_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && full && (kind_ff == bdq_pkg::KIND_APPEND ||
                            kind_ff == bdq_pkg::KIND_INSERT))
      |=> (count_ff == $past(count_ff) && status_ff == bdq_pkg::ST_FULL))
      else $error("insert into a full list changed the count");

endmodule

>>> sv/bounded_deque_with_erase.sv
// Top level of the bounded deque with erase: controller plus datapath.
// An accepted request passes through the execute state, then the response state.
// No new request is taken until the last response is taken; a stalled response holds it.
// Every operation, including erase, is done by the cell chain in the execute state.
// Reset is synchronous and active high; it empties the list and clears the controller.
module bounded_deque_with_erase (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bdq_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [bdq_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bdq_pkg::WORD_W-1:0] rsp_removed_value,
   output logic [bdq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]       rsp_count
);

   bdq_pkg::cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bdq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count)
   );

endmodule

>>> verif/tb_bounded_deque_with_erase.sv
// Self-checking testbench for the bounded deque with erase, with directed and random traffic.
`timescale 1ns / 1ps

module tb_bounded_deque_with_erase;

   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int IDLE_PCT       = 12;

   typedef struct {
      logic signed [bdq_pkg::WORD_W-1:0] removed;
      bdq_pkg::status_type               status;
      logic [bdq_pkg::COUNT_W-1:0]       count;
   } deque_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [bdq_pkg::KIND_W-1:0]          req_kind = bdq_pkg::KIND_APPEND;
   logic signed [bdq_pkg::WORD_W-1:0]   req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [bdq_pkg::WORD_W-1:0]   rsp_removed_value;
   logic [bdq_pkg::STATUS_W-1:0]        rsp_status;
   logic [bdq_pkg::COUNT_W-1:0]         rsp_count;

   logic signed [bdq_pkg::WORD_W-1:0]   shadow_list[$];
   deque_result_type                    awaited_results[$];
   int                                  mismatch_count = 0;
   bit                                  no_idle = 1'b0;
   int                                  holdoff_request = 0;
   int                                  holdoff_seen = 0;
   int                                  holdoff_left = 0;
   int                                  stuck_cycles = 0;

   bounded_deque_with_erase dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count)
   );

   always #1 clock = ~clock;

   function automatic deque_result_type step_shadow_list(
      bdq_pkg::kind_type kind, logic signed [bdq_pkg::WORD_W-1:0] value);
      deque_result_type r;
      int hit;
      r.removed = '0;
      r.status  = bdq_pkg::ST_OK;
      hit       = -1;
      case (kind)
         bdq_pkg::KIND_APPEND, bdq_pkg::KIND_INSERT: begin
            if (shadow_list.size() >= bdq_pkg::CAPACITY) begin
               r.status = bdq_pkg::ST_FULL;
            end else if (kind == bdq_pkg::KIND_APPEND) begin
               shadow_list.push_back(value);
            end else begin
               shadow_list.push_front(value);
            end
         end
         bdq_pkg::KIND_REMOVE: begin
            if (shadow_list.size() == 0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               r.removed = shadow_list.pop_front();
            end
         end
         default: begin
            if (shadow_list.size() == 0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_list.size() && hit < 0; i++) begin
                  if (shadow_list[i] == value) hit = i;
               end
               if (hit < 0) begin
                  r.status = bdq_pkg::ST_NOT_FOUND;
               end else begin
                  shadow_list.delete(hit);
               end
            end
         end
      endcase
      r.count = bdq_pkg::COUNT_W'(shadow_list.size());
      return r;
   endfunction

   task automatic send_item(bdq_pkg::kind_type kind,
                            logic signed [bdq_pkg::WORD_W-1:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(step_shadow_list(kind, value));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [bdq_pkg::WORD_W-1:0] pick_word();
      logic signed [bdq_pkg::WORD_W-1:0] w;
      case ($urandom_range(7))
         0: w = 32'sh8000_0000;
         1: w = 32'sh7FFF_FFFF;
         2: w = -1;
         3: w = $urandom_range(3);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   task automatic send_random_item(int grow_pct);
      logic signed [bdq_pkg::WORD_W-1:0] w;
      int r;
      r = $urandom_range(99);
      w = pick_word();
      if (r < grow_pct) begin
         if ($urandom_range(1) == 0) send_item(bdq_pkg::KIND_APPEND, w);
         else send_item(bdq_pkg::KIND_INSERT, w);
      end else if (r < grow_pct + (100 - grow_pct) * 2 / 5) begin
         send_item(bdq_pkg::KIND_REMOVE, w);
      end else begin
         if (shadow_list.size() != 0 && $urandom_range(99) < 85) begin
            w = shadow_list[$urandom_range(shadow_list.size() - 1)];
         end
         send_item(bdq_pkg::KIND_ERASE, w);
      end
   endtask

   task automatic test_empty_list();
      send_item(bdq_pkg::KIND_REMOVE, 32'sh1234_5678);
      send_item(bdq_pkg::KIND_ERASE, 32'sh7FFF_FFFF);
   endtask

   task automatic test_fill_to_capacity();
      send_item(bdq_pkg::KIND_INSERT, 32'sh8000_0000);
      send_item(bdq_pkg::KIND_APPEND, 32'sh7FFF_FFFF);
      send_item(bdq_pkg::KIND_INSERT, -1);
      send_item(bdq_pkg::KIND_APPEND, 0);
      for (int i = 0; i < bdq_pkg::CAPACITY - 4; i++) begin
         if (i == 3 || i == 9) send_item(bdq_pkg::KIND_APPEND, 7);
         else send_item(bdq_pkg::KIND_APPEND, 32'shA5A5_0000 + i);
      end
   endtask

   task automatic test_full_list();
      send_item(bdq_pkg::KIND_APPEND, 1);
      send_item(bdq_pkg::KIND_INSERT, 2);
   endtask

   task automatic test_erase_and_remove();
      send_item(bdq_pkg::KIND_ERASE, 7);
      send_item(bdq_pkg::KIND_ERASE, 32'sh7FFF_FFFF);
      send_item(bdq_pkg::KIND_ERASE, 32'shA5A5_0000 + bdq_pkg::CAPACITY - 5);
      send_item(bdq_pkg::KIND_ERASE, -1);
      send_item(bdq_pkg::KIND_ERASE, 32'sh0001_2345);
      send_item(bdq_pkg::KIND_REMOVE, 0);
   endtask

   task automatic test_random_mix(int n);
      for (int i = 0; i < n; i++) begin
         send_random_item(((i / 50) % 2 == 0) ? 75 : 25);
      end
   endtask

   task automatic test_receiver_holdoff();
      holdoff_request <= holdoff_request + 1;
      for (int i = 0; i < 60; i++) send_random_item(50);
   endtask

   task automatic test_sender_pause();
      wait_for_results();
      for (int i = 0; i < 100; i++) send_random_item(60);
   endtask

   task automatic test_no_idle_stretch();
      no_idle <= 1'b1;
      for (int i = 0; i < 200; i++) send_random_item((i < 100) ? 80 : 20);
      no_idle <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_seen != holdoff_request) begin
         holdoff_seen <= holdoff_request;
         holdoff_left <= HOLDOFF_CYCLES - 1;
         rsp_stall    <= 1'b1;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      deque_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected response beat: removed_value %0d status %0d count %0d",
                   rsp_removed_value, rsp_status, rsp_count);
            mismatch_count++;
         end else begin
            exp_r = awaited_results.pop_front();
            if (rsp_removed_value !== exp_r.removed) begin
               $error("removed_value: expected %0d, actual %0d", exp_r.removed,
                      rsp_removed_value);
               mismatch_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_count !== exp_r.count) begin
               $error("count: expected %0d, actual %0d", exp_r.count, rsp_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_fill_to_capacity();
      test_full_list();
      test_erase_and_remove();
      test_random_mix(400);
      test_receiver_holdoff();
      test_sender_pause();
      test_no_idle_stretch();
      test_random_mix(300);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/bdq_pkg.sv
sv/bdq_ctrl.sv
sv/bdq_datapath.sv
sv/bounded_deque_with_erase.sv
verif/tb_bounded_deque_with_erase.sv
